// ----- src/mac_dedup_pkg.sv -----
// shared types and constants for the address dedup table
// no dependencies; imported by every module of the block
package mac_dedup_pkg;

  localparam int TABLE_DEPTH = 96;
  localparam int ADDR_W      = 48;
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int OUT_COUNT_W = 7;
  localparam int GROUP_SIZE  = 8;
  localparam int NUM_GROUPS  = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic KIND_OBSERVE = 1'b0;
  localparam logic KIND_CLEAR   = 1'b1;

  localparam logic [1:0] STATUS_NEW     = 2'd0;
  localparam logic [1:0] STATUS_DUP     = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_CLEARED = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] bssid;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [OUT_COUNT_W-1:0] distinct_count;
  } rsp_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic compare;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- src/mac_dedup_cell.sv -----
// one entry of the table: holds an address, compares it, passes it on
// depends on mac_dedup_pkg
module mac_dedup_cell import mac_dedup_pkg::*; (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [ADDR_W-1:0] key,
  input  logic [ADDR_W-1:0] shift_in,
  input  logic              occupied,
  output logic [ADDR_W-1:0] entry,
  output logic              hit
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      entry <= shift_in;
    end
    if (ctrl.compare) begin
      hit <= occupied && (entry == key);
    end
  end

endmodule

// ----- src/mac_dedup_hit_group.sv -----
// registered or of one group of cell hits
// depends on mac_dedup_pkg
module mac_dedup_hit_group import mac_dedup_pkg::*; (
  input  logic                  clk,
  input  logic                  load,
  input  logic [GROUP_SIZE-1:0] hits,
  output logic                  any
);

  always_ff @(posedge clk) begin
    if (load) begin
      any <= |hits;
    end
  end

endmodule

// ----- src/mac_address_dedup_table.sv -----
// top level of the address dedup table: cell chain, hit groups and control
// depends on mac_dedup_pkg, mac_dedup_cell and mac_dedup_hit_group
//
// One word in, one word out. A word is taken only while the block is idle and
// its result is registered in the decide state, after the group state; the
// block takes no new word until it is back in idle. A result left waiting
// holds the next word in the decide state, and so holds back the word after
// it. Every cell does its compare as the word is taken; then the group state
// forms a registered or over groups of eight cells, and the decide state does
// a last or that decides and updates the table.
// New addresses enter the head of the cell chain and every held entry moves
// one cell along, so only cells below the count hold live entries. A clear
// word just zeroes the count; no clearing pass is needed after reset.
module mac_address_dedup_table import mac_dedup_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_GROUP  = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t state, state_next;

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               item_kind;
  logic [ADDR_W-1:0]  item_bssid;
  logic               accept;
  logic               rsp_free;
  logic               decide;
  logic               any_hit;
  logic               do_insert;
  logic [1:0]         status_next;
  logic [COUNT_W+OUT_COUNT_W-1:0] count_ext;
  cell_ctrl_t         ctrl;

  logic [ADDR_W-1:0]                  entry [TABLE_DEPTH];
  logic [NUM_GROUPS*GROUP_SIZE-1:0]   hit_pad;
  logic [NUM_GROUPS-1:0]              group_any;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign decide    = (state == S_DECIDE) && rsp_free;
  assign any_hit   = |group_any;

  assign ctrl.compare = accept;
  assign ctrl.shift   = do_insert;

  genvar i;
  generate
    for (i = 0; i < NUM_GROUPS * GROUP_SIZE; i++) begin : g_cell
      if (i < TABLE_DEPTH) begin : g_live
        logic cell_hit;
        mac_dedup_cell u_cell (
          .clk      (clk),
          .ctrl     (ctrl),
          .key      (req.bssid),
          .shift_in ((i == 0) ? item_bssid : entry[(i == 0) ? 0 : i - 1]),
          .occupied (count > COUNT_W'(i)),
          .entry    (entry[i]),
          .hit      (cell_hit)
        );
        assign hit_pad[i] = cell_hit;
      end else begin : g_pad
        assign hit_pad[i] = 1'b0;
      end
    end
    for (i = 0; i < NUM_GROUPS; i++) begin : g_group
      mac_dedup_hit_group u_group (
        .clk  (clk),
        .load (state == S_GROUP),
        .hits (hit_pad[i*GROUP_SIZE +: GROUP_SIZE]),
        .any  (group_any[i])
      );
    end
  endgenerate

  // outcome of the word in the decide cycle
  always_comb begin
    do_insert   = 1'b0;
    count_next  = count;
    status_next = STATUS_FULL;
    if (item_kind == KIND_CLEAR) begin
      count_next  = '0;
      status_next = STATUS_CLEARED;
    end else if (any_hit) begin
      status_next = STATUS_DUP;
    end else if (count < COUNT_W'(TABLE_DEPTH)) begin
      do_insert   = decide;
      count_next  = count + COUNT_W'(1);
      status_next = STATUS_NEW;
    end
    count_ext = {{OUT_COUNT_W{1'b0}}, count_next};
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_GROUP;
      end
      S_GROUP: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (decide) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind  <= req.kind;
      item_bssid <= req.bssid;
    end
    if (decide) begin
      rsp.status         <= status_next;
      rsp.distinct_count <= count_ext[OUT_COUNT_W-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STATUS_CLEARED |-> rsp.distinct_count == '0)
    else $error("clear result with nonzero count");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) && (count != '0) |-> count == $past(count) + COUNT_W'(1))
    else $error("count moved by more than one");

  a_insert_idle: assert property (@(posedge clk) disable iff (rst)
    do_insert |-> state == S_DECIDE && item_kind == KIND_OBSERVE)
    else $error("insert outside decide cycle");
`endif

endmodule
